// ===== hdl/smm_pkg.sv =====
// smm_pkg: shared types and constants of the square matrix multiplier
// no dependencies; imported by the controller, datapath, top level and checker

package smm_pkg;

	// fixed result field widths
	localparam int PRODUCT_W  = 35;
	localparam int INDEX_W    = 3;
	localparam int CFG_W      = 4;
	localparam int OUT_DATA_W = 48;

	// result item bit positions inside the output tdata
	localparam int PROD_LSB = 0;
	localparam int ROW_LSB  = PRODUCT_W;
	localparam int COL_LSB  = PRODUCT_W + INDEX_W;

	// matrix size after reset
	localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;

	// controller to datapath commands
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic acc_first;
		logic acc_last;
		logic out_load;
		logic out_last;
	} smm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic acc_done;
		logic out_free;
	} smm_stat_t;

endpackage

// ===== hdl/square_matrix_multiply_top.sv =====
// square_matrix_multiply_top: top level of the square matrix multiplier
// depends on smm_pkg, smm_ctrl, smm_datapath and smm_ram
//
// usage
// - cfg channel (cfg_valid/cfg_ready/cfg_data) sets the matrix size n; 0 acts
//   as 1, values above MAX_SIZE act as MAX_SIZE; a write drops a partial load
// - s_axis carries one item per element position in row-major order: an
//   element of A and the element of B at the same place; one item per cycle
// - after the n*n-th item the block stops taking items and computes C = A*B
// - m_axis delivers n*n result items in row-major order with row and column,
//   tlast on the element at row n-1, column n-1
// - each result element needs n store reads through the single read port of
//   each operand memory, then passes the read, multiply and accumulate stages
// - a stalled receiver holds the output register and the next element waits
//   in the accumulator; loading of the next pair starts while the last result
//   still waits
// - reset sets n to 8 and clears the load count; store contents are not reset
//   and no clearing pass is needed

module square_matrix_multiply_top
	import smm_pkg::*;
#(
	parameter int MAX_SIZE      = 8,
	parameter int ELEMENT_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [CFG_W-1:0]                      cfg_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// a_element, b_element, zero fill
	input  logic [((2*ELEMENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// product_element, row_index, col_index, zero fill
	output logic [OUT_DATA_W-1:0]                 m_axis_tdata,
	output logic                                  m_axis_tlast
);

	localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);

	smm_cmd_t           cmd;
	smm_stat_t          stat;
	logic [AW-1:0]      wr_addr, rd_a_addr, rd_b_addr;
	logic [INDEX_W-1:0] row_idx, col_idx;

	// size writes are always taken
	assign cfg_ready = 1'b1;

	smm_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.row_idx   (row_idx),
		.col_idx   (col_idx)
	);

	smm_datapath #(.MAX_SIZE(MAX_SIZE), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.wr_addr   (wr_addr),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.row_idx   (row_idx),
		.col_idx   (col_idx),
		.a_in      (s_axis_tdata[ELEMENT_WIDTH-1:0]),
		.b_in      (s_axis_tdata[2*ELEMENT_WIDTH-1:ELEMENT_WIDTH]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== hdl/smm_ram.sv =====
// smm_ram: generic single write, single read memory with registered read data
// no dependencies; used for both operand stores

module smm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/smm_ctrl.sv =====
// smm_ctrl: load sequencer, dot product loop counters and store addressing
// depends on smm_pkg; drives smm_datapath through smm_cmd_t

module smm_ctrl
	import smm_pkg::*;
#(
	parameter int MAX_SIZE = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [CFG_W-1:0]                     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  smm_stat_t                            stat,
	output smm_cmd_t                             cmd,
	output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] wr_addr,
	output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] rd_a_addr,
	output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] rd_b_addr,
	output logic [INDEX_W-1:0]                   row_idx,
	output logic [INDEX_W-1:0]                   col_idx
);

	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int NBW   = $clog2(MAX_SIZE + 1);
	localparam int NW    = $clog2(MAX_SIZE);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_WAIT
	} state_t;

	state_t          state_q;
	logic [CFG_W-1:0] size_q;
	logic [CW-1:0]   load_count_q;
	logic [NW-1:0]   i_q, j_q, k_q;
	logic [AW-1:0]   a_addr_q, b_addr_q, row_base_q;

	logic [NBW-1:0]  n;
	logic [NW-1:0]   n_m1;
	logic [AW-1:0]   n_a;
	logic [CW-1:0]   total;
	logic [CW-1:0]   load_next;
	logic            accept;

	// active size: zero acts as one, oversize clamps to the maximum
	always_comb begin
		int sz;
		sz = int'(size_q);
		if (sz == 0) sz = 1;
		if (sz > MAX_SIZE) sz = MAX_SIZE;
		n = NBW'(sz);
	end

	assign n_m1      = NW'(n - NBW'(1));
	assign n_a       = AW'(n);
	assign total     = CW'(n) * CW'(n);
	assign load_next = load_count_q + CW'(1);
	assign in_ready  = (state_q == ST_LOAD);
	assign accept    = in_valid && in_ready;

	// commands to the datapath
	always_comb begin
		cmd.wr_en     = accept;
		cmd.rd_en     = (state_q == ST_ISSUE);
		cmd.acc_first = (k_q == '0);
		cmd.acc_last  = (k_q == n_m1);
		cmd.out_load  = (state_q == ST_WAIT) && stat.acc_done && stat.out_free;
		cmd.out_last  = (i_q == n_m1) && (j_q == n_m1);
	end

	assign wr_addr   = load_count_q[AW-1:0];
	assign rd_a_addr = a_addr_q;
	assign rd_b_addr = b_addr_q;
	assign row_idx   = INDEX_W'(i_q);
	assign col_idx   = INDEX_W'(j_q);

	// state, size register, load count and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			size_q       <= SIZE_RESET;
			load_count_q <= '0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			a_addr_q     <= '0;
			b_addr_q     <= '0;
			row_base_q   <= '0;
		end else if (cfg_valid) begin
			// a size write drops any partial load
			size_q       <= cfg_data;
			load_count_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (load_next == total) begin
							load_count_q <= '0;
							i_q          <= '0;
							j_q          <= '0;
							k_q          <= '0;
							a_addr_q     <= '0;
							b_addr_q     <= '0;
							row_base_q   <= '0;
							state_q      <= ST_ISSUE;
						end else begin
							load_count_q <= load_next;
						end
					end
				end
				ST_ISSUE: begin
					// walk row i of A and column j of B
					a_addr_q <= a_addr_q + AW'(1);
					b_addr_q <= b_addr_q + n_a;
					if (k_q == n_m1) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + NW'(1);
					end
				end
				ST_WAIT: begin
					if (cmd.out_load) begin
						if (cmd.out_last) begin
							state_q <= ST_LOAD;
						end else if (j_q == n_m1) begin
							j_q        <= '0;
							i_q        <= i_q + NW'(1);
							row_base_q <= row_base_q + n_a;
							a_addr_q   <= row_base_q + n_a;
							b_addr_q   <= '0;
							state_q    <= ST_ISSUE;
						end else begin
							j_q      <= j_q + NW'(1);
							a_addr_q <= row_base_q;
							b_addr_q <= AW'(j_q) + AW'(1);
							state_q  <= ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== hdl/smm_datapath.sv =====
// smm_datapath: operand stores, multiply and accumulate pipeline, output register
// depends on smm_pkg and smm_ram; controlled by smm_ctrl

module smm_datapath
	import smm_pkg::*;
#(
	parameter int MAX_SIZE      = 8,
	parameter int ELEMENT_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  smm_cmd_t                             cmd,
	output smm_stat_t                            stat,
	input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] wr_addr,
	input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] rd_a_addr,
	input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] rd_b_addr,
	input  logic [INDEX_W-1:0]                   row_idx,
	input  logic [INDEX_W-1:0]                   col_idx,
	input  logic [ELEMENT_WIDTH-1:0]             a_in,
	input  logic [ELEMENT_WIDTH-1:0]             b_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [OUT_DATA_W-1:0]                out_data,
	output logic                                 out_last
);

	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int PW    = 2 * ELEMENT_WIDTH;

	logic [ELEMENT_WIDTH-1:0] a_rd_s1, b_rd_s1;
	logic                     valid_s1, first_s1, last_s1;
	logic signed [PW-1:0]     prod_s2;
	logic                     valid_s2, first_s2, last_s2;
	logic signed [PRODUCT_W-1:0] prod_ext;
	logic signed [PRODUCT_W-1:0] acc_q;
	logic                     done_q;

	logic                     out_valid_q;
	logic [PRODUCT_W-1:0]     out_prod_q;
	logic [INDEX_W-1:0]       out_row_q, out_col_q;
	logic                     out_last_q;

	// operand stores
	smm_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_left (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data (a_in),
		.rd_addr (rd_a_addr),
		.rd_data (a_rd_s1)
	);

	smm_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_right (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data (b_in),
		.rd_addr (rd_b_addr),
		.rd_data (b_rd_s1)
	);

	// product resized to the result width, wrapping like the exact sum
	generate
		if (PW >= PRODUCT_W) begin : g_trunc
			assign prod_ext = prod_s2[PRODUCT_W-1:0];
		end else begin : g_sext
			assign prod_ext = {{(PRODUCT_W-PW){prod_s2[PW-1]}}, prod_s2};
		end
	endgenerate

	// pipeline control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
			if (cmd.out_load) begin
				done_q <= 1'b0;
			end else if (valid_s2 && last_s2) begin
				done_q <= 1'b1;
			end
		end
	end

	// multiply then accumulate
	always_ff @(posedge clk) begin
		first_s1 <= cmd.acc_first;
		last_s1  <= cmd.acc_last;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		prod_s2  <= $signed(a_rd_s1) * $signed(b_rd_s1);
		if (valid_s2) begin
			acc_q <= first_s2 ? prod_ext : acc_q + prod_ext;
		end
	end

	// output register, held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_prod_q <= acc_q;
			out_row_q  <= row_idx;
			out_col_q  <= col_idx;
			out_last_q <= cmd.out_last;
		end
	end

	assign stat.acc_done = done_q;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;
	assign out_data  = {{(OUT_DATA_W-PRODUCT_W-2*INDEX_W){1'b0}},
	                    out_col_q, out_row_q, out_prod_q};

endmodule

// ===== hdl/smm_checker.sv =====
// smm_checker: port level assertions for the square matrix multiplier
// depends on smm_pkg; bound to square_matrix_multiply_top below

module smm_checker
	import smm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast
);

	// a stalled result item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item dropped while stalled");

	// a stalled result item keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result item changed while stalled");

	// no loading while the result matrix is still being produced
	a_no_load_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input taken before the result matrix finished");

	// the last element sits on the diagonal corner
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			m_axis_tdata[ROW_LSB+INDEX_W-1:ROW_LSB] == m_axis_tdata[COL_LSB+INDEX_W-1:COL_LSB])
		else $error("last element not at row n-1, column n-1");

endmodule

bind square_matrix_multiply_top smm_checker u_smm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb.sv =====
// tb: self-checking testbench of square_matrix_multiply_top, an n by n matrix multiplier
// depends on smm_pkg and square_matrix_multiply_top; a directed table of items, then random
// matrices of random size, every result checked against a predictor kept in this file

module tb
	import smm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_N       = 8;
	localparam int EL_W        = 16;
	localparam int TOTAL_ITEMS = 150;
	localparam int QUIET_FROM  = 130;
	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE      = 16;
	// longest quiet stretch of a correct run: the receiver hold-off plus one size-8
	// element plus idle pauses and gaps; taken many times over
	localparam int STALL_LIMIT = 2000;

	typedef enum bit {STEP_SIZE, STEP_PAIR} step_kind_t;

	typedef struct {
		step_kind_t      kind;
		logic [CFG_W-1:0] size;
		logic [EL_W-1:0]  a;
		logic [EL_W-1:0]  b;
		bit              fixed;
		longint          fixed_prod;
	} step_t;

	typedef struct {
		logic signed [PRODUCT_W-1:0] product;
		logic [INDEX_W-1:0]          row;
		logic [INDEX_W-1:0]          col;
		logic                        last;
	} product_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// a_element, b_element
	logic [2*EL_W-1:0]     s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// product_element, row_index, col_index, zero fill
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	// predictor state
	logic [CFG_W-1:0]       size_reg;
	int                     load_pos;
	logic signed [EL_W-1:0] a_mat [MAX_N*MAX_N];
	logic signed [EL_W-1:0] b_mat [MAX_N*MAX_N];
	product_t               product_q [$];

	int errors;
	int items_fed;
	int stall_cycles;
	bit quiet;
	bit hold_req;

	square_matrix_multiply_top #(
		.MAX_SIZE     (MAX_N),
		.ELEMENT_WIDTH(EL_W)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// size zero acts as one, sizes above the maximum act as the maximum
	function automatic int eff_size(input logic [CFG_W-1:0] s);
		if (s == 0)
			return 1;
		if (s > MAX_N)
			return MAX_N;
		return int'(s);
	endfunction

	// store one element pair; the pair that completes the load yields all of C = A*B
	task automatic load_element_pair(input logic signed [EL_W-1:0] a,
	                                 input logic signed [EL_W-1:0] b,
	                                 input bit fixed, input longint fixed_prod);
		int       n;
		int       total;
		int       pos;
		int       i;
		int       j;
		int       k;
		longint   acc;
		product_t r;
		n     = eff_size(size_reg);
		total = n * n;
		pos   = load_pos;
		if (pos >= total)
			pos = 0;
		a_mat[pos] = a;
		b_mat[pos] = b;
		pos++;
		if (pos < total) begin
			load_pos = pos;
			return;
		end
		load_pos = 0;
		for (i = 0; i < n; i++) begin
			for (j = 0; j < n; j++) begin
				acc = 0;
				for (k = 0; k < n; k++)
					acc += longint'(a_mat[i*n+k]) * longint'(b_mat[k*n+j]);
				r.product = fixed ? fixed_prod[PRODUCT_W-1:0] : acc[PRODUCT_W-1:0];
				r.row     = i[INDEX_W-1:0];
				r.col     = j[INDEX_W-1:0];
				r.last    = (i == n - 1) && (j == n - 1);
				product_q.insert(product_q.size(), r);
			end
		end
	endtask

	// offer one item, with an occasional gap before it, and wait for its acceptance
	task automatic feed_pair(input logic [EL_W-1:0] a, input logic [EL_W-1:0] b,
	                         input bit fixed, input longint fixed_prod);
		if (items_fed >= QUIET_FROM)
			quiet = 1'b1;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, a};
		do @(posedge clk); while (!s_axis_tready);
		load_element_pair(a, b, fixed, fixed_prod);
		items_fed++;
	endtask

	// size writes happen only once every pending result is out and the block has settled
	task automatic write_matrix_size(input logic [CFG_W-1:0] v);
		s_axis_tvalid <= 1'b0;
		while (product_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_reg = v;
		load_pos = 0;
	endtask

	// extremes come up often, the rest is random
	function automatic logic [EL_W-1:0] rand_element();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return EL_W'($urandom);
		endcase
	endfunction

	task automatic feed_random(input int count);
		repeat (count) feed_pair(rand_element(), rand_element(), 1'b0, 0);
	endtask

	// stimulus
	initial begin : stimulus
		step_t steps [27];
		int    idx;
		int    n;
		steps = '{
			// partial load at the reset size, dropped by the next size write
			'{STEP_PAIR, 4'd0, 16'h1234, 16'h5678, 1'b0, 64'sd0},
			// size zero acts as one: single-element products at the extremes
			'{STEP_SIZE, 4'd0, 16'h0000, 16'h0000, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h7FFF, 16'h7FFF, 1'b1, 64'sd1073676289},
			'{STEP_PAIR, 4'd0, 16'h8000, 16'h8000, 1'b1, 64'sd1073741824},
			'{STEP_PAIR, 4'd0, 16'h8000, 16'h7FFF, 1'b1, -64'sd1073709056},
			'{STEP_PAIR, 4'd0, 16'h0000, 16'hFFFF, 1'b1, 64'sd0},
			'{STEP_SIZE, 4'd1, 16'h0000, 16'h0000, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h0001, 16'hFFFF, 1'b1, -64'sd1},
			// size written mid-load drops the three items before it
			'{STEP_SIZE, 4'd2, 16'h0000, 16'h0000, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h0001, 16'h0002, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h0003, 16'h0004, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h0005, 16'h0006, 1'b0, 64'sd0},
			'{STEP_SIZE, 4'd2, 16'h0000, 16'h0000, 1'b0, 64'sd0},
			// all most-negative: every dot product is 2^31
			'{STEP_PAIR, 4'd0, 16'h8000, 16'h8000, 1'b1, 64'sd2147483648},
			'{STEP_PAIR, 4'd0, 16'h8000, 16'h8000, 1'b1, 64'sd2147483648},
			'{STEP_PAIR, 4'd0, 16'h8000, 16'h8000, 1'b1, 64'sd2147483648},
			'{STEP_PAIR, 4'd0, 16'h8000, 16'h8000, 1'b1, 64'sd2147483648},
			// 3x3 ordering of rows and columns
			'{STEP_SIZE, 4'd3, 16'h0000, 16'h0000, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h0001, 16'hFFFF, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h0002, 16'hFFFE, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h0003, 16'hFFFD, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h0004, 16'hFFFC, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h0005, 16'hFFFB, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h0006, 16'hFFFA, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h0007, 16'hFFF9, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h0008, 16'hFFF8, 1'b0, 64'sd0},
			'{STEP_PAIR, 4'd0, 16'h0009, 16'hFFF7, 1'b0, 64'sd0}
		};
		errors    = 0;
		items_fed = 0;
		quiet     = 1'b0;
		hold_req  = 1'b0;
		size_reg  = SIZE_RESET;
		load_pos  = 0;

		// reset
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (idx = 0; idx < $size(steps); idx++) begin
			if (steps[idx].kind == STEP_SIZE)
				write_matrix_size(steps[idx].size);
			else
				feed_pair(steps[idx].a, steps[idx].b, steps[idx].fixed, steps[idx].fixed_prod);
		end

		// largest code acts as the maximum size: one full 8x8 product
		write_matrix_size(4'd15);
		feed_random(64);

		// small matrices back to back while the receiver holds off for a long stretch
		write_matrix_size(4'd2);
		hold_req = 1'b1;
		feed_random(16);

		// random sizes, whole matrices, sometimes a partial load dropped by the next write
		while (items_fed < TOTAL_ITEMS) begin
			write_matrix_size(CFG_W'($urandom_range(0, 5)));
			n = eff_size(size_reg);
			feed_random($urandom_range(1, 2) * n * n);
			if (n > 1 && $urandom_range(0, 3) == 0)
				feed_random($urandom_range(1, n * n - 1));
		end

		// drain
		s_axis_tvalid <= 1'b0;
		while (product_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// result side: check each accepted item, then choose the next ready
	initial begin : result_sink
		int          gap_left;
		int          hold_left;
		product_t    want;
		logic signed [PRODUCT_W-1:0] got_prod;
		logic [INDEX_W-1:0]          got_row;
		logic [INDEX_W-1:0]          got_col;
		gap_left  = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got_prod = m_axis_tdata[PROD_LSB +: PRODUCT_W];
				got_row  = m_axis_tdata[ROW_LSB +: INDEX_W];
				got_col  = m_axis_tdata[COL_LSB +: INDEX_W];
				if (product_q.size() == 0) begin
					$display("%0t: unexpected result prod %0d row %0d col %0d last %0b",
						$realtime, got_prod, got_row, got_col, m_axis_tlast);
					errors++;
				end else begin
					want = product_q.pop_front();
					if (got_prod !== want.product || got_row !== want.row ||
					    got_col !== want.col || m_axis_tlast !== want.last) begin
						$display("%0t: mismatch expected prod %0d row %0d col %0d last %0b",
							$realtime, want.product, want.row, want.col, want.last);
						$display("%0t:          actual prod %0d row %0d col %0d last %0b",
							$realtime, got_prod, got_row, got_col, m_axis_tlast);
						errors++;
					end
				end
			end
			// one long hold-off, counted here, so the block fills and stalls its input
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				gap_left = $urandom_range(1, 4) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake of any kind
	initial stall_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
